>>> src/cmu_pkg.sv
// ----------------------------------------------------------------------------
// cmu_pkg: shared definitions for the conductance membrane update block
// Defaults, register indexes, the attenuation table and the stage types.
// ----------------------------------------------------------------------------
package cmu_pkg;

  localparam int NUM_PIXELS_DEF = 4096;
  localparam int NUM_PORTS_DEF  = 4;
  localparam int MAX_PORTS      = 4;

  // Leak conductance after reset: 50.0 in Q16.16.
  localparam logic [30:0] LEAK_RESET = 31'd3276800;

  // Attenuation is a product over the bits of dt*gt; the divider makes one
  // quotient bit per stage.
  localparam int ATT_STEPS = 21;
  localparam int DIV_STEPS = 32;

  // round(exp(-2^(k-16)) * 2^31) for bit k of dt*gt in Q16.16.
  localparam logic [30:0] EXP_TAB [ATT_STEPS] = '{
    31'd2147450880, 31'd2147418113, 31'd2147352580, 31'd2147221520,
    31'd2146959424, 31'd2146435328, 31'd2145387520, 31'd2143293437,
    31'd2139111403, 31'd2130771798, 31'd2114190000, 31'd2081412522,
    31'd2017374191, 31'd1895147668, 31'd1672461947, 31'd1302514674,
    31'd790015084,  31'd290630308,  31'd39332535,   31'd720401,
    31'd242
  };

  typedef enum logic [2:0] {
    REG_LEAK = 3'd0,
    REG_STEP = 3'd1,
    REG_REV0 = 3'd2,
    REG_REV1 = 3'd3,
    REG_REV2 = 3'd4,
    REG_REV3 = 3'd5
  } cfg_reg_e;

  // One stage of the shared divide and attenuation pipeline.
  typedef struct packed {
    logic [11:0] addr;
    logic        bad;
    logic        neg;
    logic        over;
    logic [34:0] dvs;
    logic [34:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
    logic [31:0] att;
    logic [20:0] xb;
    logic        azero;
  } div_t;

  // One transaction waiting in the output buffer.
  typedef struct packed {
    logic [11:0] addr;
    logic [31:0] pot;
    logic        bad;
  } out_t;

endpackage

>>> src/conductance_membrane_update.sv
// ----------------------------------------------------------------------------
// conductance_membrane_update: per-pixel conductance-based membrane update
// Throughput: one transaction per cycle while nothing stalls the front stages;
// the front stalls when the output buffer is full, and two back-to-back
// transactions on the same pixel stall it as well, set by the read-modify-write
// of the RAM. After reset the potential RAM is cleared, one entry per cycle,
// through all NUM_PIXELS entries, during which no input transaction is accepted.
// ----------------------------------------------------------------------------
module conductance_membrane_update #(
  parameter int NUM_PIXELS = cmu_pkg::NUM_PIXELS_DEF,
  parameter int NUM_PORTS  = cmu_pkg::NUM_PORTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // input transactions
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [11:0]        pixel_index_i,
  input  logic signed [31:0] port_value_0_i,
  input  logic signed [31:0] port_value_1_i,
  input  logic signed [31:0] port_value_2_i,
  input  logic signed [31:0] port_value_3_i,
  // output transactions
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [11:0]        out_pixel_index_o,
  output logic signed [31:0] new_potential_o,
  output logic               bad_conductance_o
);

  localparam int AW   = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
  localparam int NP   = cmu_pkg::MAX_PORTS;
  localparam int NDIV = cmu_pkg::DIV_STEPS;
  // Front stages: input, products, sums, scaling products, divider setup,
  // the divider stages, target and the RAM data stage (M).
  localparam int NF   = NDIV + 7;
  localparam int ST_M = NF - 1;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never stalls.
  // --------------------------------------------------------------------------
  logic [30:0]          leak_q;
  logic [31:0]          step_q;
  logic [NP-1:0][31:0]  erev_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leak_q <= cmu_pkg::LEAK_RESET;
      step_q <= '0;
      erev_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cmu_pkg::REG_LEAK: leak_q    <= cfg_data_i[30:0];
        cmu_pkg::REG_STEP: step_q    <= cfg_data_i;
        cmu_pkg::REG_REV0: erev_q[0] <= cfg_data_i;
        cmu_pkg::REG_REV1: erev_q[1] <= cfg_data_i;
        cmu_pkg::REG_REV2: erev_q[2] <= cfg_data_i;
        cmu_pkg::REG_REV3: erev_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control. The front stages (input through M) move together on
  // front; stage A's valid bit moves on en, its data on front. en drops only
  // when the two-entry output buffer is full, so a waiting result does not
  // block new input. front also drops for one cycle when the transaction in
  // M addresses the same pixel as A, whose result is not written back yet.
  // --------------------------------------------------------------------------
  logic [NF-1:0] fv_q;
  logic          va_q;
  logic [1:0]    ocnt_q;
  logic          clearing_q;
  logic [AW-1:0] clr_q;
  logic          en;
  logic          haz;
  logic          front;

  logic [11:0]   m_addr_q;
  logic [11:0]   a_addr_q;

  assign en         = (ocnt_q != 2'd2);
  assign haz        = fv_q[ST_M] & va_q & (m_addr_q == a_addr_q);
  assign front      = en & ~haz;
  assign in_ready_o = front & ~clearing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      va_q <= 1'b0;
    end else begin
      if (front) begin
        fv_q <= {fv_q[NF-2:0], in_valid_i & ~clearing_q};
      end
      if (en) begin
        va_q <= front & fv_q[ST_M];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input registers.
  // --------------------------------------------------------------------------
  logic [NP-1:0][31:0] in_val;
  logic [11:0]         s0_addr_q;
  logic [NP-1:0][31:0] s0_val_q;

  assign in_val[0] = port_value_0_i;
  assign in_val[1] = port_value_1_i;
  assign in_val[2] = port_value_2_i;
  assign in_val[3] = port_value_3_i;

  always_ff @(posedge clk_i) begin
    if (front) begin
      s0_addr_q <= pixel_index_i;
      s0_val_q  <= in_val;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: one g*Erev product per port. A port with a zero reversal
  // potential carries a current; ports beyond NUM_PORTS are ignored.
  // --------------------------------------------------------------------------
  logic [NP-1:0][63:0] s1_prod_d;
  logic [NP-1:0]       s1_cond_d;
  logic [NP-1:0]       s1_cur_d;
  logic [11:0]         s1_addr_q;
  logic [NP-1:0][31:0] s1_val_q;
  logic [NP-1:0][63:0] s1_prod_q;
  logic [NP-1:0]       s1_cond_q;
  logic [NP-1:0]       s1_cur_q;

  always_comb begin
    for (int c = 0; c < NP; c++) begin
      s1_prod_d[c] = 64'($signed(s0_val_q[c])) * 64'($signed(erev_q[c]));
      s1_cond_d[c] = (erev_q[c] != '0) && (c < NUM_PORTS);
      s1_cur_d[c]  = (erev_q[c] == '0) && (c < NUM_PORTS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (front) begin
      s1_addr_q <= s0_addr_q;
      s1_val_q  <= s0_val_q;
      s1_prod_q <= s1_prod_d;
      s1_cond_q <= s1_cond_d;
      s1_cur_q  <= s1_cur_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: total conductance and numerator. Each product is scaled back
  // to Q16.16 with truncation toward zero.
  // --------------------------------------------------------------------------
  logic signed [51:0] s2_num_d;
  logic signed [35:0] s2_gt_d;
  logic [11:0]        s2_addr_q;
  logic signed [51:0] s2_num_q;
  logic signed [35:0] s2_gt_q;

  always_comb begin
    logic [63:0]        adj;
    logic signed [47:0] tq;
    s2_num_d = '0;
    s2_gt_d  = $signed({5'b0, leak_q});
    adj      = '0;
    tq       = '0;
    for (int c = 0; c < NP; c++) begin
      if (s1_cond_q[c]) begin
        adj      = s1_prod_q[c] + (s1_prod_q[c][63] ? 64'd65535 : 64'd0);
        tq       = 48'($signed(adj) >>> 16);
        s2_num_d = s2_num_d + 52'(tq);
        s2_gt_d  = s2_gt_d + 36'($signed(s1_val_q[c]));
      end else if (s1_cur_q[c]) begin
        s2_num_d = s2_num_d + 52'($signed(s1_val_q[c]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (front) begin
      s2_addr_q <= s1_addr_q;
      s2_num_q  <= s2_num_d;
      s2_gt_q   <= s2_gt_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign and magnitude for the divider, saturation check, and the
  // two partial products of dt*gt.
  // --------------------------------------------------------------------------
  logic        s3_bad_d;
  logic        s3_neg_d;
  logic [51:0] s3_mag_d;
  logic        s3_over_d;
  logic [63:0] s3_plo_d;
  logic [34:0] s3_phi_d;

  logic [11:0] s3_addr_q;
  logic        s3_bad_q;
  logic        s3_neg_q;
  logic [51:0] s3_mag_q;
  logic [34:0] s3_dvs_q;
  logic        s3_over_q;
  logic [31:0] s3_plo_q;
  logic [34:0] s3_phi_q;

  always_comb begin
    s3_bad_d  = s2_gt_q[35] | (s2_gt_q == '0);
    s3_neg_d  = s2_num_q[51];
    s3_mag_d  = s3_neg_d ? 52'(-s2_num_q) : 52'(s2_num_q);
    s3_over_d = s3_mag_d >= {1'b0, s2_gt_q[34:0], 16'h0000};
    s3_plo_d  = 64'(step_q) * 64'(s2_gt_q[31:0]);
    s3_phi_d  = 35'(step_q) * 35'(s2_gt_q[34:32]);
  end

  always_ff @(posedge clk_i) begin
    if (front) begin
      s3_addr_q <= s2_addr_q;
      s3_bad_q  <= s3_bad_d;
      s3_neg_q  <= s3_neg_d;
      s3_mag_q  <= s3_mag_d;
      s3_dvs_q  <= s2_gt_q[34:0];
      s3_over_q <= s3_over_d;
      s3_plo_q  <= s3_plo_d[63:32];
      s3_phi_q  <= s3_phi_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: divider setup. The dividend is mag*2^16; the upper part seeds
  // the partial remainder and the lower 32 bits are shifted in one a stage.
  // x = dt*gt in Q16.16 selects the attenuation factors.
  // --------------------------------------------------------------------------
  cmu_pkg::div_t div_init;
  cmu_pkg::div_t div_q [NDIV+1];
  logic [35:0]   x_sum;

  always_comb begin
    x_sum          = {1'b0, s3_phi_q} + {4'b0, s3_plo_q};
    div_init.addr  = s3_addr_q;
    div_init.bad   = s3_bad_q;
    div_init.neg   = s3_neg_q;
    div_init.over  = s3_over_q;
    div_init.dvs   = s3_dvs_q;
    div_init.rem   = s3_mag_q[50:16];
    div_init.low   = {s3_mag_q[15:0], 16'h0000};
    div_init.quo   = '0;
    div_init.att   = 32'h8000_0000;
    div_init.xb    = x_sum[20:0];
    div_init.azero = |x_sum[35:21];
  end

  always_ff @(posedge clk_i) begin
    if (front) begin
      div_q[0] <= div_init;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: one restoring quotient bit per stage. The first stages
  // also apply one attenuation factor each, in increasing bit order.
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    cmu_pkg::div_t nxt;
    logic [35:0]   trial;
    logic          ge;
    logic [31:0]   att_n;

    if (k < cmu_pkg::ATT_STEPS) begin : g_att
      logic [62:0] aprod;
      assign aprod = 63'(div_q[k].att) * 63'(cmu_pkg::EXP_TAB[k]);
      assign att_n = div_q[k].xb[k] ? aprod[62:31] : div_q[k].att;
    end else begin : g_pass
      assign att_n = div_q[k].att;
    end

    always_comb begin
      trial   = {div_q[k].rem, div_q[k].low[31]};
      ge      = trial >= {1'b0, div_q[k].dvs};
      nxt     = div_q[k];
      nxt.rem = ge ? 35'(trial - {1'b0, div_q[k].dvs}) : trial[34:0];
      nxt.low = {div_q[k].low[30:0], 1'b0};
      nxt.quo = {div_q[k].quo[30:0], ge};
      nxt.att = att_n;
    end

    always_ff @(posedge clk_i) begin
      if (front) begin
        div_q[k+1] <= nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage T: signed, saturated target potential and final attenuation.
  // The RAM read for this pixel is issued as it moves on to M.
  // --------------------------------------------------------------------------
  cmu_pkg::div_t      dv;
  logic [32:0]        tres;
  logic signed [31:0] t_target_d;
  logic [11:0]        t_addr_q;
  logic               t_inr_q;
  logic               t_bad_q;
  logic signed [31:0] t_target_q;
  logic [31:0]        t_att_q;

  assign dv = div_q[NDIV];

  always_comb begin
    tres = dv.over ? 33'h1_0000_0000 : {1'b0, dv.quo};
    if (dv.neg) begin
      t_target_d = (tres > 33'h0_8000_0000) ? 32'sh8000_0000 : 32'(-tres);
    end else begin
      t_target_d = (tres > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : tres[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (front) begin
      t_addr_q   <= dv.addr;
      t_inr_q    <= ({20'd0, dv.addr} < 32'(NUM_PIXELS));
      t_bad_q    <= dv.bad;
      t_target_q <= t_target_d;
      t_att_q    <= dv.azero ? 32'd0 : dv.att;
    end
  end

  // --------------------------------------------------------------------------
  // Potential RAM with the reset clearing pass.
  // --------------------------------------------------------------------------
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [31:0]   rdata;
  logic          a_we;
  logic [31:0]   a_res;

  assign we    = clearing_q | (en & va_q & a_we);
  assign waddr = clearing_q ? clr_q : AW'(a_addr_q);
  assign wdata = clearing_q ? 32'd0 : a_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == AW'(NUM_PIXELS - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  cmu_ram #(
    .WIDTH(32),
    .DEPTH(NUM_PIXELS)
  ) u_pot_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (front),
    .raddr_i(AW'(t_addr_q)),
    .rdata_o(rdata)
  );

  // --------------------------------------------------------------------------
  // Stage M: the stored potential arrives. A write to the same pixel that
  // lands at or after the read is caught in the forwarding register: on
  // the edge the transaction enters M, and on every edge it waits there.
  // --------------------------------------------------------------------------
  logic               fwd_v_q;
  logic [31:0]        fwd_d_q;
  logic               m_inr_q;
  logic               m_bad_q;
  logic signed [31:0] m_target_q;
  logic [31:0]        m_att_q;
  logic signed [31:0] m_v;
  logic signed [32:0] m_diff;
  logic signed [65:0] m_prod;
  logic               fwd_hit_t;
  logic               fwd_hit_m;

  assign fwd_hit_t = we & (waddr == AW'(t_addr_q));
  assign fwd_hit_m = we & (waddr == AW'(m_addr_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (front) begin
      fwd_v_q <= fwd_hit_t;
    end else if (fwd_hit_m) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (front || fwd_hit_m) begin
      fwd_d_q <= wdata;
    end
    if (front) begin
      m_addr_q   <= t_addr_q;
      m_inr_q    <= t_inr_q;
      m_bad_q    <= t_bad_q;
      m_target_q <= t_target_q;
      m_att_q    <= t_att_q;
    end
  end

  assign m_v    = fwd_v_q ? fwd_d_q : rdata;
  assign m_diff = 33'(m_v) - 33'(m_target_q);
  assign m_prod = 66'(m_diff) * $signed({34'd0, m_att_q});

  // --------------------------------------------------------------------------
  // Stage A: (V - E)*a / 2^31 toward zero, plus E, saturated. The result is
  // written back as it moves to the output buffer.
  // --------------------------------------------------------------------------
  logic signed [65:0] a_prod_q;
  logic signed [31:0] a_target_q;
  logic signed [31:0] a_v_q;
  logic               a_inr_q;
  logic               a_bad_q;
  logic [65:0]        a_adj;
  logic signed [34:0] a_sh;
  logic signed [35:0] a_sum;
  logic [31:0]        a_sat;

  always_ff @(posedge clk_i) begin
    if (front) begin
      a_prod_q   <= m_prod;
      a_target_q <= m_target_q;
      a_v_q      <= m_v;
      a_addr_q   <= m_addr_q;
      a_inr_q    <= m_inr_q;
      a_bad_q    <= m_bad_q;
    end
  end

  always_comb begin
    a_adj = a_prod_q + (a_prod_q[65] ? 66'h0_7FFF_FFFF : 66'd0);
    a_sh  = 35'($signed(a_adj) >>> 31);
    a_sum = 36'(a_sh) + 36'(a_target_q);
    if (a_sum > 36'sh0_7FFF_FFFF) begin
      a_sat = 32'h7FFF_FFFF;
    end else if (a_sum < -36'sh0_8000_0000) begin
      a_sat = 32'h8000_0000;
    end else begin
      a_sat = a_sum[31:0];
    end
    // A pixel outside the map reports zero; a bad total keeps the potential.
    if (!a_inr_q) begin
      a_res = '0;
    end else if (a_bad_q) begin
      a_res = a_v_q;
    end else begin
      a_res = a_sat;
    end
    a_we = a_inr_q & ~a_bad_q;
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer.
  // --------------------------------------------------------------------------
  cmu_pkg::out_t ob_new;
  cmu_pkg::out_t ob_head_q;
  cmu_pkg::out_t ob_tail_q;
  logic          push;
  logic          pop;

  assign ob_new.addr = a_addr_q;
  assign ob_new.pot  = a_res;
  assign ob_new.bad  = a_inr_q & a_bad_q;

  assign push = en & va_q;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else begin
      ocnt_q <= ocnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && pop) begin
      if (ocnt_q == 2'd2) begin
        ob_head_q <= ob_tail_q;
        ob_tail_q <= ob_new;
      end else begin
        ob_head_q <= ob_new;
      end
    end else if (pop) begin
      ob_head_q <= ob_tail_q;
    end else if (push) begin
      if (ocnt_q == 2'd0) begin
        ob_head_q <= ob_new;
      end else begin
        ob_tail_q <= ob_new;
      end
    end
  end

  assign out_valid_o       = (ocnt_q != 2'd0);
  assign out_pixel_index_o = ob_head_q.addr;
  assign new_potential_o   = ob_head_q.pot;
  assign bad_conductance_o = ob_head_q.bad;

endmodule

>>> src/cmu_ram.sv
// ----------------------------------------------------------------------------
// cmu_ram: generic single-clock RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module cmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read in the same cycle as a write to the same entry returns old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
